// ----- hw/rtl/ptrd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrd_pkg: shared types and constants of the pressure trend detector
// Default geometry, reset values, sequencer states and the result bundle.
// ----------------------------------------------------------------------------
package ptrd_pkg;

    // default geometry
    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int MEAN_WINDOW_DEF  = 8;
    localparam int SAMPLE_BITS_DEF  = 24;

    // threshold register
    localparam int         THR_BITS  = 8;
    localparam logic [7:0] THR_RESET = 8'd16;

    // reported vote field
    localparam int VOTE_OUT_BITS = 7;
    localparam int VOTE_SAT_MAX  = 63;
    localparam int VOTE_SAT_MIN  = -64;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SAMPLE_WR,
        ST_SUM_RD,
        ST_SUM_DRAIN,
        ST_SUM_WR,
        ST_PAIR_RD,
        ST_PAIR_DRAIN,
        ST_DONE
    } ptrd_state_t;

    // finished result handed to the output register
    typedef struct packed {
        logic                             valid;
        logic                             apoapsis_flag;
        logic signed [VOTE_OUT_BITS-1:0]  trend_vote;
    } ptrd_result_t;

endpackage

// ----- hw/rtl/ptrd_ring_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrd_ring_mem: ring storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ptrd_ring_mem #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/ptrd_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrd_seq: sample/sum sequencer
// Clears both rings after reset, writes each sample, sums the window by
// reading the sample ring, stores the sum, then, if there are pairs, walks
// the stored sums pair by pair to build the trend vote.
// ----------------------------------------------------------------------------
module ptrd_seq #(
    parameter int BUFFER_DEPTH = ptrd_pkg::BUFFER_DEPTH_DEF,
    parameter int MEAN_WINDOW  = ptrd_pkg::MEAN_WINDOW_DEF,
    parameter int SAMPLE_BITS  = ptrd_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_BITS     = SAMPLE_BITS + $clog2(MEAN_WINDOW)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beat
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [SAMPLE_BITS-1:0]          s_pressure_sample,
    // threshold write
    input  logic                            cfg_wr_en,
    input  logic [ptrd_pkg::THR_BITS-1:0]   cfg_wr_data,
    // result toward the output register
    output ptrd_pkg::ptrd_result_t          res,
    input  logic                            out_free,
    // sample ring
    output logic                            samp_wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] samp_wr_addr,
    output logic [SAMPLE_BITS-1:0]          samp_wr_data,
    output logic                            samp_rd_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] samp_rd_addr,
    input  logic [SAMPLE_BITS-1:0]          samp_rd_data,
    // sum ring
    output logic                            sum_wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] sum_wr_addr,
    output logic [SUM_BITS-1:0]             sum_wr_data,
    output logic                            sum_rd_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] sum_rd_addr,
    input  logic [SUM_BITS-1:0]             sum_rd_data
);

    import ptrd_pkg::*;

    localparam int AW         = $clog2(BUFFER_DEPTH);
    localparam int PAIRS      = BUFFER_DEPTH - 1 - MEAN_WINDOW;
    localparam bit HAS_PAIRS  = (PAIRS > 0);
    localparam int PAIR_READS = HAS_PAIRS ? PAIRS + 1 : 1;
    localparam int STEP_MAX   = (MEAN_WINDOW > PAIR_READS) ? MEAN_WINDOW : PAIR_READS;
    localparam int CW         = $clog2(STEP_MAX + 1);
    localparam int PAIRS_POS  = HAS_PAIRS ? PAIRS : 1;
    localparam int VB_RAW     = $clog2(PAIRS_POS + 1) + 1;
    localparam int VB         = (VB_RAW < THR_BITS + 2) ? THR_BITS + 2 : VB_RAW;

    localparam logic [AW-1:0]        LAST_SLOT = AW'(BUFFER_DEPTH - 1);
    localparam logic [CW-1:0]        SUM_LAST  = CW'(MEAN_WINDOW - 1);
    localparam logic [CW-1:0]        PAIR_LAST = CW'(PAIR_READS - 1);
    localparam logic signed [VB-1:0] SAT_HI    = VB'(VOTE_SAT_MAX);
    localparam logic signed [VB-1:0] SAT_LO    = VB'(VOTE_SAT_MIN);

    ptrd_state_t state_reg, state_next;

    logic [AW-1:0]          ws_reg, ws_next;
    logic [AW-1:0]          addr_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   rd_pipe_reg;
    logic [THR_BITS-1:0]    thr_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SUM_BITS-1:0]    acc_reg;
    logic [SUM_BITS-1:0]    prev_reg;
    logic                   have_prev_reg;
    logic signed [VB-1:0]   vote_reg;

    logic [AW-1:0]          ws_inc, addr_inc, addr_dec;
    logic signed [VB-1:0]   thr_neg;
    logic signed [VB-1:0]   vote_sat;

    // ring pointer arithmetic, depth need not be a power of two
    assign ws_inc   = (ws_reg == LAST_SLOT) ? '0 : ws_reg + 1'b1;
    assign addr_inc = (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;
    assign addr_dec = (addr_reg == '0) ? LAST_SLOT : addr_reg - 1'b1;
    assign ws_next  = ws_inc;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:      if (addr_reg == LAST_SLOT) state_next = ST_IDLE;
            ST_IDLE:       if (s_valid) state_next = ST_SAMPLE_WR;
            ST_SAMPLE_WR:  state_next = ST_SUM_RD;
            ST_SUM_RD:     if (cnt_reg == SUM_LAST) state_next = ST_SUM_DRAIN;
            ST_SUM_DRAIN:  state_next = ST_SUM_WR;
            ST_SUM_WR:     state_next = HAS_PAIRS ? ST_PAIR_RD : ST_DONE;
            ST_PAIR_RD:    if (cnt_reg == PAIR_LAST) state_next = ST_PAIR_DRAIN;
            ST_PAIR_DRAIN: state_next = ST_DONE;
            ST_DONE:       if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_CLEAR;
        endcase
    end

    // memory controls and handshake
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        samp_wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_SAMPLE_WR);
        samp_wr_addr = (state_reg == ST_CLEAR) ? addr_reg : ws_reg;
        samp_wr_data = (state_reg == ST_CLEAR) ? '0 : sample_reg;
        samp_rd_en   = (state_reg == ST_SUM_RD);
        samp_rd_addr = addr_reg;
        sum_wr_en    = (state_reg == ST_CLEAR) || (state_reg == ST_SUM_WR);
        sum_wr_addr  = (state_reg == ST_CLEAR) ? addr_reg : ws_reg;
        sum_wr_data  = (state_reg == ST_CLEAR) ? '0 : acc_reg;
        sum_rd_en    = (state_reg == ST_PAIR_RD);
        sum_rd_addr  = addr_reg;
    end

    // flag from the exact vote, report saturated
    assign thr_neg = -$signed({{(VB - THR_BITS){1'b0}}, thr_reg});

    always_comb begin
        if (vote_reg > SAT_HI) begin
            vote_sat = SAT_HI;
        end else if (vote_reg < SAT_LO) begin
            vote_sat = SAT_LO;
        end else begin
            vote_sat = vote_reg;
        end
    end

    assign res.valid         = (state_reg == ST_DONE);
    assign res.apoapsis_flag = (vote_reg < thr_neg);
    assign res.trend_vote    = vote_sat[VOTE_OUT_BITS-1:0];

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg      <= LAST_SLOT;
            addr_reg    <= '0;
            cnt_reg     <= '0;
            rd_pipe_reg <= 1'b0;
            thr_reg     <= THR_RESET;
        end else begin
            rd_pipe_reg <= samp_rd_en || sum_rd_en;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    addr_reg <= addr_inc;
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        ws_reg   <= ws_next;
                        addr_reg <= ws_next;
                        cnt_reg  <= '0;
                    end
                end
                ST_SUM_RD: begin
                    addr_reg <= addr_dec;
                    cnt_reg  <= (cnt_reg == SUM_LAST) ? '0 : cnt_reg + 1'b1;
                end
                ST_SUM_WR: begin
                    addr_reg <= ws_inc;
                    cnt_reg  <= '0;
                end
                ST_PAIR_RD: begin
                    addr_reg <= addr_inc;
                    cnt_reg  <= (cnt_reg == PAIR_LAST) ? '0 : cnt_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath: sample capture, window sum, pair vote
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_pressure_sample;
            acc_reg    <= '0;
        end
        if (rd_pipe_reg && (state_reg == ST_SUM_RD || state_reg == ST_SUM_DRAIN)) begin
            acc_reg <= acc_reg + SUM_BITS'(samp_rd_data);
        end
        if (state_reg == ST_SUM_WR) begin
            vote_reg      <= '0;
            have_prev_reg <= 1'b0;
        end
        if (rd_pipe_reg && (state_reg == ST_PAIR_RD || state_reg == ST_PAIR_DRAIN)) begin
            prev_reg      <= sum_rd_data;
            have_prev_reg <= 1'b1;
            if (have_prev_reg) begin
                // non-rising pair votes up, rising pair votes down
                vote_reg <= (sum_rd_data <= prev_reg) ? vote_reg + 1'b1 : vote_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/pressure_trend_reversal_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_trend_reversal_detector: moving-sum trend vote apoapsis detector
// Input channel s_*: one pressure sample per beat. Output channel m_*: one
// result per sample, the apoapsis flag and the saturated trend vote.
// cfg_wr_en / cfg_wr_data write the 8-bit trigger threshold (reset 16) at
// any edge the enable is high; write it only while the block is idle.
// After reset a clearing pass zeroes both rings, one slot a cycle, over all
// BUFFER_DEPTH slots; s_ready stays low during it.
// Each sample is written to the sample ring, its window is summed through
// the sample ring's single read port, the sum is stored, and the stored sums
// are walked through the sum ring's single read port. With no pairs to
// compare (MEAN_WINDOW >= BUFFER_DEPTH-1) the walk is skipped. A new sample
// is taken only after the result of the previous one has left the sequencer.
// A finished result waits in the output register while the receiver stalls;
// the next sample can be taken meanwhile and its result holds inside until
// the output register frees.
// ----------------------------------------------------------------------------
module pressure_trend_reversal_detector #(
    parameter int BUFFER_DEPTH = ptrd_pkg::BUFFER_DEPTH_DEF,
    parameter int MEAN_WINDOW  = ptrd_pkg::MEAN_WINDOW_DEF,
    parameter int SAMPLE_BITS  = ptrd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [SAMPLE_BITS-1:0]                    s_pressure_sample,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic                                      m_apoapsis_flag,
    output logic signed [ptrd_pkg::VOTE_OUT_BITS-1:0] m_trend_vote,
    input  logic                                      cfg_wr_en,
    input  logic [ptrd_pkg::THR_BITS-1:0]             cfg_wr_data
);

    import ptrd_pkg::*;

    localparam int AW       = $clog2(BUFFER_DEPTH);
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MEAN_WINDOW);

    ptrd_result_t res;
    logic         out_free;

    logic                   samp_wr_en, samp_rd_en;
    logic [AW-1:0]          samp_wr_addr, samp_rd_addr;
    logic [SAMPLE_BITS-1:0] samp_wr_data, samp_rd_data;
    logic                   sum_wr_en, sum_rd_en;
    logic [AW-1:0]          sum_wr_addr, sum_rd_addr;
    logic [SUM_BITS-1:0]    sum_wr_data, sum_rd_data;

    logic                            m_valid_reg, m_valid_next;
    logic                            m_flag_reg;
    logic signed [VOTE_OUT_BITS-1:0] m_vote_reg;

    ptrd_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MEAN_WINDOW  (MEAN_WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SUM_BITS     (SUM_BITS)
    ) u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pressure_sample (s_pressure_sample),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .res               (res),
        .out_free          (out_free),
        .samp_wr_en        (samp_wr_en),
        .samp_wr_addr      (samp_wr_addr),
        .samp_wr_data      (samp_wr_data),
        .samp_rd_en        (samp_rd_en),
        .samp_rd_addr      (samp_rd_addr),
        .samp_rd_data      (samp_rd_data),
        .sum_wr_en         (sum_wr_en),
        .sum_wr_addr       (sum_wr_addr),
        .sum_wr_data       (sum_wr_data),
        .sum_rd_en         (sum_rd_en),
        .sum_rd_addr       (sum_rd_addr),
        .sum_rd_data       (sum_rd_data)
    );

    ptrd_ring_mem #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_sample_ring (
        .aclk    (aclk),
        .wr_en   (samp_wr_en),
        .wr_addr (samp_wr_addr),
        .wr_data (samp_wr_data),
        .rd_en   (samp_rd_en),
        .rd_addr (samp_rd_addr),
        .rd_data (samp_rd_data)
    );

    ptrd_ring_mem #(
        .WIDTH (SUM_BITS),
        .DEPTH (BUFFER_DEPTH)
    ) u_sum_ring (
        .aclk    (aclk),
        .wr_en   (sum_wr_en),
        .wr_addr (sum_wr_addr),
        .wr_data (sum_wr_data),
        .rd_en   (sum_rd_en),
        .rd_addr (sum_rd_addr),
        .rd_data (sum_rd_data)
    );

    // output register: free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res.valid && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid && out_free) begin
            m_flag_reg <= res.apoapsis_flag;
            m_vote_reg <= res.trend_vote;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_apoapsis_flag = m_flag_reg;
    assign m_trend_vote    = m_vote_reg;

`ifndef SYNTHESIS
    // one sample in flight: no accept on the cycle after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sample accepted while previous one still in work");

    // a raised flag always comes with a negative vote
    a_flag_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_apoapsis_flag) |-> m_trend_vote[VOTE_OUT_BITS-1])
        else $error("apoapsis flag with non-negative vote");

    // clearing pass holds off input right after reset
    a_clear_hold: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during ring clearing");
`endif

endmodule
